/* design/ps2_mouse_cursor_tracker_core_macros.svh */
// Assertion macros shared by the cursor tracker RTL.
`ifndef PS2_MOUSE_CURSOR_TRACKER_CORE_MACROS_SVH
`define PS2_MOUSE_CURSOR_TRACKER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define PS2MCT_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("ps2mct: implication check failed");

// Next-cycle implication, disabled during reset.
`define PS2MCT_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("ps2mct: next-cycle check failed");

`else

`define PS2MCT_ASSERT_IMPLIES(label, clk, rst, cond, expr)
`define PS2MCT_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

/* design/ps2mct_pkg.sv */
// Types and constants for the PS/2 mouse cursor tracker.
package ps2mct_pkg;

   localparam int unsigned COORD_W = 8;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [7:0]         byte_type;

   // Bit 3 of the first packet byte is always set; used for framing.
   localparam byte_type  SYNC_BIT     = 8'h08;
   localparam coord_type RESET_WIDTH  = 8'd80;
   localparam coord_type RESET_HEIGHT = 8'd25;
   localparam coord_type RESET_COL    = coord_type'(RESET_WIDTH / 8'd2);
   localparam coord_type RESET_ROW    = coord_type'(RESET_HEIGHT / 8'd2);

   typedef enum logic [0:0] {
      CSR_SCREEN_WIDTH  = 1'b0,
      CSR_SCREEN_HEIGHT = 1'b1
   } csr_index_type;

   // Next expected byte of the three-byte packet.
   typedef enum logic [2:0] {
      PH_HEAD   = 3'b001,
      PH_XDELTA = 3'b010,
      PH_YDELTA = 3'b100
   } phase_type;

   typedef struct packed {
      coord_type col;
      coord_type row;
   } cursor_type;

endpackage

/* design/ps2mct_axis_clamp.sv */
// One cursor axis: add or subtract a signed byte delta, saturate to screen size.
module ps2mct_axis_clamp (
   input  ps2mct_pkg::coord_type position,
   input  ps2mct_pkg::byte_type  delta,
   input  logic                  negate,
   input  ps2mct_pkg::coord_type screen_size,
   output ps2mct_pkg::coord_type next_position
);
   import ps2mct_pkg::*;

   // -128 .. 383 fits in 10 signed bits
   logic signed [COORD_W+1:0] delta_ext;
   logic signed [COORD_W+1:0] pos_ext;
   logic signed [COORD_W+1:0] sum;
   coord_type                 top;

   always_comb begin
      delta_ext = {{2{delta[7]}}, delta};
      pos_ext   = {2'b00, position};
      sum       = negate ? (pos_ext - delta_ext) : (pos_ext + delta_ext);
      // size 0 behaves as size 1
      top       = (screen_size == '0) ? '0 : (screen_size - coord_type'(1));
      if (sum[COORD_W+1]) begin
         next_position = '0;
      end else if (sum[COORD_W:0] > {1'b0, top}) begin
         next_position = top;
      end else begin
         next_position = sum[COORD_W-1:0];
      end
   end

endmodule

/* design/ps2_mouse_cursor_tracker_core.sv */
// Top level: PS/2 mouse packet framing and clamped cursor position tracking.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+------------------------------------
//   req     | in  | req_valid/req_ready  | req_data_byte[7:0], req_from_aux
//   rsp     | out | rsp_valid/rsp_ready  | rsp_cursor_col[7:0], rsp_cursor_row[7:0]
//   csr     | in  | csr_valid/csr_ready  | csr_index (0 width, 1 height), csr_data
//
// One item per cycle while req_ready is high. Framing state and cursor position
// update at the accept edge; the third packet byte registers its result into the
// output register or, behind an earlier result, into the skid entry. A two-entry
// output (register plus skid) keeps req_ready high while one result waits;
// req_ready drops only with both entries full. Synchronous reset: framing to first
// byte, cursor to 40/12, sizes to 80/25. csr_ready is always high.
`include "ps2_mouse_cursor_tracker_core_macros.svh"

module ps2_mouse_cursor_tracker_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  ps2mct_pkg::byte_type      req_data_byte,
   input  logic                      req_from_aux,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output ps2mct_pkg::coord_type     rsp_cursor_col,
   output ps2mct_pkg::coord_type     rsp_cursor_row,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  ps2mct_pkg::csr_index_type csr_index,
   input  ps2mct_pkg::byte_type      csr_data
);
   import ps2mct_pkg::*;

   // configuration
   coord_type width_ff, width_in;
   coord_type height_ff, height_in;

   // packet framing and cursor state
   phase_type phase_ff, phase_in;
   byte_type  held_x_ff, held_x_in;
   coord_type col_ff, col_in;
   coord_type row_ff, row_in;

   // output register and skid entry
   logic       out_valid_ff, out_valid_in;
   cursor_type out_ff, out_in;
   logic       skid_valid_ff, skid_valid_in;
   cursor_type skid_ff, skid_in;

   logic       req_take;
   logic       mouse_byte;
   logic       res_valid;
   cursor_type res;
   coord_type  col_next;
   coord_type  row_next;

   assign req_ready  = !skid_valid_ff;
   assign req_take   = req_valid && req_ready;
   assign mouse_byte = req_take && req_from_aux;
   assign csr_ready  = 1'b1;

   // X from the held second byte, Y from the current (third) byte; screen Y
   // grows downward, so the mouse Y delta is subtracted.
   ps2mct_axis_clamp u_col_clamp (
      .position      (col_ff),
      .delta         (held_x_ff),
      .negate        (1'b0),
      .screen_size   (width_ff),
      .next_position (col_next)
   );

   ps2mct_axis_clamp u_row_clamp (
      .position      (row_ff),
      .delta         (req_data_byte),
      .negate        (1'b1),
      .screen_size   (height_ff),
      .next_position (row_next)
   );

   // configuration writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  width_in  = csr_data;
            CSR_SCREEN_HEIGHT: height_in = csr_data;
         endcase
      end
   end

   // packet framing
   always_comb begin
      phase_in  = phase_ff;
      held_x_in = held_x_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      res_valid = 1'b0;
      res.col   = col_next;
      res.row   = row_next;
      if (mouse_byte) begin
         unique case (phase_ff)
            PH_XDELTA: begin
               held_x_in = req_data_byte;
               phase_in  = PH_YDELTA;
            end
            PH_YDELTA: begin
               phase_in  = PH_HEAD;
               col_in    = col_next;
               row_in    = row_next;
               res_valid = 1'b1;
            end
            default: begin
               // first byte; a clear sync bit means we are out of step
               phase_in = ((req_data_byte & SYNC_BIT) != '0) ? PH_XDELTA : PH_HEAD;
            end
         endcase
      end
   end

   // two-entry output; skid only takes a result while an earlier one is still queued ahead of it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = res_valid;
            skid_in       = res;
         end else begin
            out_valid_in  = res_valid;
            out_in        = res;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= RESET_WIDTH;
         height_ff     <= RESET_HEIGHT;
         phase_ff      <= PH_HEAD;
         held_x_ff     <= '0;
         col_ff        <= RESET_COL;
         row_ff        <= RESET_ROW;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         phase_ff      <= phase_in;
         held_x_ff     <= held_x_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_cursor_col = out_ff.col;
   assign rsp_cursor_row = out_ff.row;

   // skid entry never holds an item ahead of an empty output register
   `PS2MCT_ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)

   // a completed packet always leaves the output register valid next cycle
   `PS2MCT_ASSERT_NEXT(a_packet_gives_item, clock, reset,
      mouse_byte && (phase_ff == PH_YDELTA), out_valid_ff)

   // emitted column stays inside the configured width
   `PS2MCT_ASSERT_IMPLIES(a_col_in_range, clock, reset, out_valid_ff,
      (out_ff.col == '0) || (out_ff.col < width_ff))

endmodule

/* dv/tb_ps2_mouse_cursor_tracker_core.sv */
// Testbench for the PS/2 mouse cursor tracker: packet framing, cursor clamping, flow control.
module tb_ps2_mouse_cursor_tracker_core;
   timeunit 1ns;
   timeprecision 1ps;

   import ps2mct_pkg::*;

   // Own copies of the architectural constants, so a wrong package value gets caught.
   localparam byte_type  HEAD_SYNC   = 8'h08;
   localparam coord_type HOME_COL    = 8'd40;
   localparam coord_type HOME_ROW    = 8'd12;
   localparam coord_type BOOT_WIDTH  = 8'd80;
   localparam coord_type BOOT_HEIGHT = 8'd25;

   localparam int unsigned RANDOM_AUX_ITEMS = 1200;
   localparam int unsigned RSP_HOLD_CYCLES  = 400;
   localparam int unsigned MAX_PRINTED      = 40;

   // ---------------------------------------------------------------------------------------------
   // Clock, reset and DUT ports. Every input has a known value from time zero.
   // ---------------------------------------------------------------------------------------------
   logic          clock         = 1'b0;
   logic          reset         = 1'b1;
   logic          req_valid     = 1'b0;
   logic          req_ready;
   byte_type      req_data_byte = '0;
   logic          req_from_aux  = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready     = 1'b0;
   coord_type     rsp_cursor_col;
   coord_type     rsp_cursor_row;
   logic          csr_valid     = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index     = CSR_SCREEN_WIDTH;
   byte_type      csr_data      = '0;

   always #1 clock = ~clock;

   ps2_mouse_cursor_tracker_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_from_aux   (req_from_aux),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // ---------------------------------------------------------------------------------------------
   // Cursor predictor state: framing phase, held X byte, position and screen size.
   // Only the monitor below touches these.
   // ---------------------------------------------------------------------------------------------
   phase_type  pkt_phase;
   byte_type   held_x;
   coord_type  cur_col;
   coord_type  cur_row;
   coord_type  scr_width;
   coord_type  scr_height;
   cursor_type expected_cursor_q[$];

   int unsigned error_count     = 0;
   int unsigned aux_items_sent  = 0;
   bit          idle_on         = 1'b1;   // random gaps on both sides when set
   int unsigned hold_requests   = 0;      // bumped by a test to ask for one long rsp stall

   task automatic log_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   // Saturate to 0 .. size-1; a size of 0 behaves as 1.
   function automatic coord_type clamp_to_screen(input int v, input coord_type size);
      int top;
      top = (size == 0) ? 0 : int'(size) - 1;
      if (v < 0)
         return '0;
      if (v > top)
         return coord_type'(top);
      return coord_type'(v);
   endfunction

   // Predict the effect of one accepted byte; a completed packet queues the new position.
   task automatic track_mouse_byte(input byte_type data, input logic aux);
      cursor_type landed;
      int         col_sum;
      int         row_sum;
      int         dx;
      int         dy;
      if (!aux)
         return;   // keyboard bytes leave everything alone
      case (pkt_phase)
         PH_XDELTA: begin
            held_x    = data;
            pkt_phase = PH_YDELTA;
         end
         PH_YDELTA: begin
            dx         = $signed(held_x);
            dy         = $signed(data);
            col_sum    = cur_col;
            row_sum    = cur_row;
            cur_col    = clamp_to_screen(col_sum + dx, scr_width);
            cur_row    = clamp_to_screen(row_sum - dy, scr_height);   // screen Y grows downward
            pkt_phase  = PH_HEAD;
            landed.col = cur_col;
            landed.row = cur_row;
            expected_cursor_q.push_back(landed);
         end
         default: begin
            // A head byte without the sync bit is refused; framing stays put.
            if ((data & HEAD_SYNC) != 0)
               pkt_phase = PH_XDELTA;
            else
               pkt_phase = PH_HEAD;
         end
      endcase
   endtask

   // ---------------------------------------------------------------------------------------------
   // Monitor: samples all three channels at each rising edge, before any NBA of that edge lands.
   // Results are checked before the same edge's input is predicted, so a result can only ever
   // match an item accepted on an earlier edge.
   // ---------------------------------------------------------------------------------------------
   always @(posedge clock) begin : channel_monitor
      cursor_type want;
      if (reset) begin
         pkt_phase  = PH_HEAD;
         held_x     = '0;
         cur_col    = HOME_COL;
         cur_row    = HOME_ROW;
         scr_width  = BOOT_WIDTH;
         scr_height = BOOT_HEIGHT;
         expected_cursor_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_cursor_q.size() == 0) begin
               log_mismatch($sformatf("unexpected cursor %0d/%0d", rsp_cursor_col,
                                      rsp_cursor_row));
            end else begin
               want = expected_cursor_q.pop_front();
               if (rsp_cursor_col !== want.col)
                  log_mismatch($sformatf("cursor_col got %0d want %0d", rsp_cursor_col,
                                         want.col));
               if (rsp_cursor_row !== want.row)
                  log_mismatch($sformatf("cursor_row got %0d want %0d", rsp_cursor_row,
                                         want.row));
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SCREEN_WIDTH)
               scr_width = csr_data;
            else if (csr_index == CSR_SCREEN_HEIGHT)
               scr_height = csr_data;
         end
         if (req_valid && req_ready)
            track_mouse_byte(req_data_byte, req_from_aux);
      end
   end

   // Idle length: half the time none, else usually drawn from the lower range below, now and then from the upper one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 10)
         return 0;
      if (r < 18)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ---------------------------------------------------------------------------------------------
   // Result-side pacing. A long hold-off, when a test asks for one, is counted here.
   // ---------------------------------------------------------------------------------------------
   int unsigned hold_served  = 0;
   int unsigned stall_left   = 0;
   int unsigned rsp_gap_left = 0;

   always @(posedge clock) begin : rsp_pacer
      if (hold_served != hold_requests) begin
         hold_served++;
         stall_left = RSP_HOLD_CYCLES;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!idle_on) begin
         rsp_ready <= 1'b1;
      end else if (rsp_gap_left != 0) begin
         rsp_gap_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready    <= 1'b1;
         rsp_gap_left = pick_gap();
      end
   end

   // ---------------------------------------------------------------------------------------------
   // Stimulus helpers. All run right after a rising edge; valid is only lowered when a gap
   // follows, so it is never dropped and raised in the same step.
   // ---------------------------------------------------------------------------------------------
   task automatic send_item(input byte_type data, input logic aux);
      int unsigned gap;
      gap = idle_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_from_aux  <= aux;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (aux)
         aux_items_sent++;
   endtask

   task automatic send_packet(input byte_type head, input byte_type dx, input byte_type dy);
      send_item(head, 1'b1);
      send_item(dx, 1'b1);
      send_item(dy, 1'b1);
   endtask

   // Let every expected cursor arrive, then wait for the output stage to settle.
   task automatic drain_outstanding();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_cursor_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Only called with the block idle.
   task automatic write_csr(input csr_index_type idx, input byte_type value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic byte_type pick_screen_size();
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return 8'd1;
         2:       return 8'd255;
         3:       return 8'd2;
         default: return byte_type'($urandom_range(1, 255));
      endcase
   endfunction

   // Deltas: mostly small moves, some full range, some at the signed extremes.
   function automatic byte_type pick_delta();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 12)
         return byte_type'($urandom_range(0, 16) - 8);
      if (r < 17)
         return byte_type'($urandom_range(0, 255));
      return (r == 17) ? 8'h7F : 8'h80;
   endfunction

   // ---------------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------------

   // Reset position, saturation at both ends of both axes, refused heads, keyboard bytes
   // dropped at the head and in the middle of a packet.
   task automatic test_packet_framing();
      send_packet(8'h08, 8'h00, 8'h00);   // no move: home position 40/12
      send_packet(8'hFF, 8'h7F, 8'h80);   // right and down, clamps to 79/24
      send_packet(8'h08, 8'h80, 8'h7F);   // left and up, clamps to 0/0
      send_item(8'h00, 1'b1);             // refused head
      send_item(8'hF7, 1'b1);             // refused head, every bit but sync set
      send_item(8'hFF, 1'b0);             // keyboard byte at head position
      send_item(8'h18, 1'b1);
      send_item(8'hAA, 1'b0);             // keyboard byte inside a packet
      send_item(8'h05, 1'b1);
      send_item(8'h55, 1'b0);
      send_item(8'hFB, 1'b1);             // lands at 5/5
      send_packet(8'h28, 8'hFF, 8'h01);   // one step left and up: 4/4
   endtask

   // Screen size extremes, including zero, and a resize that only takes effect on the
   // next packet.
   task automatic test_screen_limits();
      drain_outstanding();
      write_csr(CSR_SCREEN_WIDTH, 8'd1);
      write_csr(CSR_SCREEN_HEIGHT, 8'd1);
      send_packet(8'h08, 8'h00, 8'h00);
      drain_outstanding();
      write_csr(CSR_SCREEN_WIDTH, 8'd0);
      write_csr(CSR_SCREEN_HEIGHT, 8'd0);
      send_packet(8'h08, 8'h7F, 8'h80);
      drain_outstanding();
      write_csr(CSR_SCREEN_WIDTH, 8'd255);
      write_csr(CSR_SCREEN_HEIGHT, 8'd255);
      send_packet(8'h08, 8'h7F, 8'h80);
      send_packet(8'h08, 8'h7F, 8'h80);   // runs into 254/254
      drain_outstanding();
      write_csr(CSR_SCREEN_WIDTH, 8'd10);
      write_csr(CSR_SCREEN_HEIGHT, 8'd5);
      send_packet(8'h08, 8'h00, 8'h00);   // shrink pulls the cursor in to 9/4
      drain_outstanding();
      write_csr(CSR_SCREEN_WIDTH, BOOT_WIDTH);
      write_csr(CSR_SCREEN_HEIGHT, BOOT_HEIGHT);
   endtask

   // Mostly well-formed packets with random content; the rest refused heads, stray mouse bytes
   // that knock the framing off, and keyboard noise. Screen size and pacing change per phase.
   task automatic test_random_traffic();
      int unsigned stop_at;
      int unsigned target;
      int unsigned kind;
      target = aux_items_sent + RANDOM_AUX_ITEMS;
      while (aux_items_sent < target) begin
         drain_outstanding();
         write_csr(CSR_SCREEN_WIDTH, pick_screen_size());
         write_csr(CSR_SCREEN_HEIGHT, pick_screen_size());
         idle_on = ($urandom_range(0, 3) != 0);
         stop_at = aux_items_sent + $urandom_range(100, 250);
         if (stop_at > target)
            stop_at = target;
         while (aux_items_sent < stop_at) begin
            kind = $urandom_range(0, 19);
            if (kind < 16) begin
               send_item(byte_type'($urandom_range(0, 255)) | HEAD_SYNC, 1'b1);
               if ($urandom_range(0, 9) == 0)
                  send_item(byte_type'($urandom_range(0, 255)), 1'b0);
               send_item(pick_delta(), 1'b1);
               if ($urandom_range(0, 9) == 0)
                  send_item(byte_type'($urandom_range(0, 255)), 1'b0);
               send_item(pick_delta(), 1'b1);
            end else if (kind < 18) begin
               send_item(byte_type'($urandom_range(0, 255)) & ~HEAD_SYNC, 1'b1);
            end else if (kind < 19) begin
               send_item(byte_type'($urandom_range(0, 255)), 1'b1);
            end else begin
               send_item(byte_type'($urandom_range(0, 255)), 1'b0);
            end
         end
      end
      idle_on = 1'b1;
   endtask

   // Receiver goes quiet for a long stretch while packets keep coming back to back: both
   // output entries fill and req_ready must drop until the receiver wakes up.
   task automatic test_output_backpressure();
      drain_outstanding();
      idle_on = 1'b0;
      hold_requests <= hold_requests + 1;
      repeat (20)
         send_packet(byte_type'($urandom_range(0, 255)) | HEAD_SYNC, pick_delta(), pick_delta());
      idle_on = 1'b1;
   endtask

   initial begin : main_sequence
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_packet_framing();
      test_screen_limits();
      test_output_backpressure();
      test_random_traffic();
      test_output_backpressure();
      drain_outstanding();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin : run_limit
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+design
design/ps2mct_pkg.sv
design/ps2mct_axis_clamp.sv
design/ps2_mouse_cursor_tracker_core.sv
dv/tb_ps2_mouse_cursor_tracker_core.sv
